### hw/rtl/ffba_pkg.sv
// Shared types, constants and helpers of the first-fit block allocator.
`default_nettype none

package ffba_pkg;

  // Slot map row geometry: one row of slots is scanned or written per cycle.
  localparam int ROW_BITS = 4;
  localparam int ROW_W    = 1 << ROW_BITS;

  // Owner id field width and the number of ids it can name.
  localparam int ID_W    = 8;
  localparam int ID_SPAN = 1 << ID_W;

  // Width of the seat count register and its reset value.
  localparam int          SEAT_W     = 11;
  localparam logic [10:0] SEAT_RESET = 11'd1024;

  // Width of the block length field.
  localparam int LEN_IN_W = 11;

  // Command codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK,
    ST_FINISH
  } ffba_state_e;

  // Row write request to the slot map: fill selects set or clear.
  typedef struct packed {
    logic en;
    logic fill;
  } ffba_row_wr_t;

  // Owner table update: set records an entry and marks it held, clr frees it.
  typedef struct packed {
    logic set;
    logic clr;
  } ffba_own_wr_t;

  // Bits lo up to but not including hi of one row.
  function automatic logic [ROW_W-1:0] row_mask(input logic [ROW_BITS:0] lo,
                                                input logic [ROW_BITS:0] hi);
    logic [ROW_W-1:0] m;
    for (int k = 0; k < ROW_W; k++) begin
      m[k] = ((ROW_BITS+1)'(k) >= lo) && ((ROW_BITS+1)'(k) < hi);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/first_fit_block_allocator.sv
// Top level of the first-fit block allocator: sequencer, tables and ports.
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per request:
//   cmd_i selects allocate or release, owner_id_i names the owner and
//   block_length_i the slots wanted. Output channel (out_valid_o /
//   out_stall_i) returns one word per request with accepted_o set when granted.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the seat count; write
//   it only while no request is in flight.
// Timing: one request at a time, in_stall_o stays high while it is worked.
//   The slot map is scanned one row of 16 slots per cycle through a single
//   row scan unit, then the block is written one row per cycle.
//   Allocate: owner check, then rows scanned up to the fit, then the rows
//   of the block written. Release: owner check, then the block rows cleared.
//   A request refused at the owner check or with no fit goes to finish.
// Reset: the map reads all free and no owner holds a block at once, through
//   per-row and per-owner valid flags; no clearing pass is needed.
// Back pressure: a finished word waits in the output register while
//   out_stall_i is high; a new request is still taken meanwhile, and its
//   result waits in the finish step until the register frees.
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_SLOTS  = 1024,
  parameter int MAX_OWNERS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ffba_pkg::SEAT_W-1:0]    cfg_seat_count_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [ffba_pkg::ID_W-1:0]      owner_id_i,
  input  logic [ffba_pkg::LEN_IN_W-1:0]  block_length_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accepted_o
);

  localparam int NumRows  = (MAX_SLOTS + ffba_pkg::ROW_W - 1) / ffba_pkg::ROW_W;
  localparam int RowAw    = (NumRows > 1) ? $clog2(NumRows) : 1;
  localparam int PosW     = RowAw + ffba_pkg::ROW_BITS + 1;
  localparam int OwnDepth = (MAX_OWNERS < ffba_pkg::ID_SPAN) ? MAX_OWNERS : ffba_pkg::ID_SPAN;
  localparam int OwnAw    = $clog2(OwnDepth);
  localparam logic [RowAw-1:0] LastRow = RowAw'(NumRows - 1);

  // Control state
  ffba_pkg::ffba_state_e state_q, state_d;
  logic [ffba_pkg::SEAT_W-1:0] seat_q, seat_d;
  logic pend_q, pend_d;
  logic out_valid_q, out_valid_d;

  // Per-request payload
  logic                 cmd_q, cmd_d;
  logic [OwnAw-1:0]     id_q, id_d;
  logic                 id_ok_q, id_ok_d;
  logic                 len_ok_q, len_ok_d;
  logic [PosW-1:0]      len_q, len_d;
  logic [PosW-1:0]      limit_q, limit_d;
  logic [RowAw-1:0]     issue_q, issue_d;
  logic [RowAw-1:0]     proc_row_q, proc_row_d;
  logic [PosW-1:0]      carry_q, carry_d;
  logic [PosW-1:0]      cur_q, cur_d;
  logic [PosW-1:0]      end_q, end_d;
  logic                 fill_q, fill_d;
  logic                 res_q, res_d;
  logic                 acc_q, acc_d;

  logic                 in_fire;
  logic [31:0]          seat_ext;
  logic [PosW-1:0]      limit_now;
  logic                 id_in_range;
  logic                 len_fits;

  // Owner table wiring
  ffba_pkg::ffba_own_wr_t own_wr;
  logic                   own_rd_valid;
  logic [PosW-2:0]        own_rd_start;
  logic [PosW-1:0]        own_rd_len;

  // Slot map and scan unit wiring
  ffba_pkg::ffba_row_wr_t     row_wr;
  logic                       slot_rd_en;
  logic [ffba_pkg::ROW_W-1:0] slot_row;
  logic [ffba_pkg::ROW_W-1:0] mark_mask;
  logic                       run_hit;
  logic [PosW-2:0]            run_start;
  logic [PosW-1:0]            run_carry;
  logic                       run_last;
  logic [PosW-1:0]            scan_base;

  // Mark step: the part of the block that falls in the current row
  logic [ffba_pkg::ROW_BITS:0] mark_lo;
  logic [ffba_pkg::ROW_BITS:0] mark_span;
  logic [ffba_pkg::ROW_BITS:0] mark_hi;
  logic [PosW-1:0]             mark_rem;
  logic                        mark_last;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ffba_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == ffba_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accepted_o  = acc_q;

  // Usable slots: the seat count, clipped to the map size.
  assign seat_ext    = 32'(seat_q);
  assign limit_now   = (seat_ext > 32'(MAX_SLOTS)) ? PosW'(MAX_SLOTS) : PosW'(seat_ext);
  assign id_in_range = 32'(owner_id_i) < 32'(MAX_OWNERS);
  assign len_fits    = (block_length_i != '0) && (32'(block_length_i) <= 32'(limit_now));

  assign scan_base = PosW'({proc_row_q, {ffba_pkg::ROW_BITS{1'b0}}});

  assign mark_lo   = {1'b0, cur_q[ffba_pkg::ROW_BITS-1:0]};
  assign mark_span = (ffba_pkg::ROW_BITS+1)'(ffba_pkg::ROW_W) - mark_lo;
  assign mark_rem  = end_q - cur_q;
  assign mark_last = mark_rem <= PosW'(mark_span);
  assign mark_hi   = mark_last ? mark_lo + mark_rem[ffba_pkg::ROW_BITS:0]
                               : (ffba_pkg::ROW_BITS+1)'(ffba_pkg::ROW_W);
  assign mark_mask = ffba_pkg::row_mask(mark_lo, mark_hi);

  ffba_owner_table #(
    .DEPTH   (OwnDepth),
    .AW      (OwnAw),
    .START_W (PosW - 1),
    .LEN_W   (PosW)
  ) u_owner_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_fire),
    .rd_addr_i  (owner_id_i[OwnAw-1:0]),
    .rd_valid_o (own_rd_valid),
    .rd_start_o (own_rd_start),
    .rd_len_o   (own_rd_len),
    .wr_i       (own_wr),
    .wr_addr_i  (id_q),
    .wr_start_i (run_start),
    .wr_len_i   (len_q)
  );

  ffba_slot_map #(
    .NUM_ROWS (NumRows),
    .ROW_AW   (RowAw)
  ) u_slot_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (slot_rd_en),
    .rd_addr_i (issue_q),
    .rd_row_o  (slot_row),
    .wr_i      (row_wr),
    .wr_addr_i (cur_q[PosW-2:ffba_pkg::ROW_BITS]),
    .wr_mask_i (mark_mask)
  );

  ffba_run_unit #(
    .POS_W (PosW)
  ) u_run_unit (
    .row_i   (slot_row),
    .base_i  (scan_base),
    .limit_i (limit_q),
    .carry_i (carry_q),
    .len_i   (len_q),
    .hit_o   (run_hit),
    .start_o (run_start),
    .carry_o (run_carry),
    .last_o  (run_last)
  );

  // Sequencer: check the owner, scan rows for a fit, write the block rows,
  // then hand the result to the output register.
  always_comb begin
    state_d     = state_q;
    seat_d      = seat_q;
    pend_d      = pend_q;
    cmd_d       = cmd_q;
    id_d        = id_q;
    id_ok_d     = id_ok_q;
    len_ok_d    = len_ok_q;
    len_d       = len_q;
    limit_d     = limit_q;
    issue_d     = issue_q;
    proc_row_d  = proc_row_q;
    carry_d     = carry_q;
    cur_d       = cur_q;
    end_d       = end_q;
    fill_d      = fill_q;
    res_d       = res_q;
    acc_d       = acc_q;
    own_wr      = '0;
    row_wr      = '0;
    slot_rd_en  = 1'b0;
    // Drop the output word once taken.
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_valid_i && cfg_ready_o) begin
      seat_d = cfg_seat_count_i;
    end

    unique case (state_q)
      ffba_pkg::ST_IDLE: begin
        if (in_fire) begin
          cmd_d    = cmd_i;
          id_d     = owner_id_i[OwnAw-1:0];
          id_ok_d  = id_in_range;
          len_ok_d = len_fits;
          len_d    = PosW'(block_length_i);
          limit_d  = limit_now;
          state_d  = ffba_pkg::ST_CHECK;
        end
      end

      ffba_pkg::ST_CHECK: begin
        priority if (!id_ok_q) begin
          res_d   = 1'b0;
          state_d = ffba_pkg::ST_FINISH;
        end else if (cmd_q == ffba_pkg::CMD_RELEASE) begin
          if (!own_rd_valid) begin
            res_d   = 1'b0;
            state_d = ffba_pkg::ST_FINISH;
          end else begin
            own_wr.clr = 1'b1;
            cur_d      = PosW'(own_rd_start);
            end_d      = PosW'(own_rd_start) + own_rd_len;
            fill_d     = 1'b0;
            res_d      = 1'b1;
            state_d    = ffba_pkg::ST_MARK;
          end
        end else if (own_rd_valid || !len_ok_q) begin
          res_d   = 1'b0;
          state_d = ffba_pkg::ST_FINISH;
        end else begin
          issue_d = '0;
          pend_d  = 1'b0;
          carry_d = '0;
          state_d = ffba_pkg::ST_SCAN;
        end
      end

      ffba_pkg::ST_SCAN: begin
        // Issue the next row read while the previous row is scanned.
        slot_rd_en = 1'b1;
        proc_row_d = issue_q;
        pend_d     = 1'b1;
        if (issue_q != LastRow) begin
          issue_d = issue_q + RowAw'(1);
        end
        if (pend_q) begin
          priority if (run_hit) begin
            own_wr.set = 1'b1;
            cur_d      = PosW'(run_start);
            end_d      = PosW'(run_start) + len_q;
            fill_d     = 1'b1;
            res_d      = 1'b1;
            pend_d     = 1'b0;
            state_d    = ffba_pkg::ST_MARK;
          end else if (run_last) begin
            res_d   = 1'b0;
            pend_d  = 1'b0;
            state_d = ffba_pkg::ST_FINISH;
          end else begin
            carry_d = run_carry;
          end
        end
      end

      ffba_pkg::ST_MARK: begin
        row_wr.en   = 1'b1;
        row_wr.fill = fill_q;
        if (mark_last) begin
          state_d = ffba_pkg::ST_FINISH;
        end else begin
          // Advance to the first slot of the next row.
          cur_d = {cur_q[PosW-1:ffba_pkg::ROW_BITS] + (PosW-ffba_pkg::ROW_BITS)'(1),
                   {ffba_pkg::ROW_BITS{1'b0}}};
        end
      end

      ffba_pkg::ST_FINISH: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          acc_d       = res_q;
          state_d     = ffba_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ffba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::ST_IDLE;
      seat_q      <= ffba_pkg::SEAT_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seat_q      <= seat_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    id_q       <= id_d;
    id_ok_q    <= id_ok_d;
    len_ok_q   <= len_ok_d;
    len_q      <= len_d;
    limit_q    <= limit_d;
    issue_q    <= issue_d;
    proc_row_q <= proc_row_d;
    carry_q    <= carry_d;
    cur_q      <= cur_d;
    end_q      <= end_d;
    fill_q     <= fill_d;
    res_q      <= res_d;
    acc_q      <= acc_d;
  end

`ifndef SYNTHESIS
  // A block being written never runs past its end.
  a_mark_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ffba_pkg::ST_MARK |-> cur_q < end_q)
    else $error("mark pointer at or past block end");

  // A fit found by the scan lies inside the usable slots.
  a_fit_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffba_pkg::ST_SCAN && pend_q && run_hit) |->
      ((PosW+1)'(run_start) + (PosW+1)'(len_q)) <= (PosW+1)'(limit_q))
    else $error("fit extends past usable slots");

  // A result word only appears from the finish step.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ffba_pkg::ST_FINISH))
    else $error("result word loaded outside finish step");

  // An accepted request always goes to the owner check next.
  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ffba_pkg::ST_CHECK)
    else $error("accepted request did not reach owner check");
`endif

endmodule

`default_nettype wire

### hw/rtl/ffba_slot_map.sv
// Slot occupancy map: one row of slots per word, with per-row valid bits.
`default_nettype none

module ffba_slot_map #(
  parameter int NUM_ROWS = 64,
  parameter int ROW_AW   = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [ROW_AW-1:0]           rd_addr_i,
  output logic [ffba_pkg::ROW_W-1:0]  rd_row_o,
  input  ffba_pkg::ffba_row_wr_t      wr_i,
  input  logic [ROW_AW-1:0]           wr_addr_i,
  input  logic [ffba_pkg::ROW_W-1:0]  wr_mask_i
);

  logic [ffba_pkg::ROW_W-1:0] mem_q [NUM_ROWS];
  logic [NUM_ROWS-1:0]        row_valid_q;
  logic [ffba_pkg::ROW_W-1:0] rd_data_q;
  logic                       rd_valid_q;

  // A row never written reads as all free; its first write fills every bit.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      for (int b = 0; b < ffba_pkg::ROW_W; b++) begin
        if (!row_valid_q[wr_addr_i] || wr_mask_i[b]) begin
          mem_q[wr_addr_i][b] <= wr_i.fill & wr_mask_i[b];
        end
      end
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  assign rd_row_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### hw/rtl/ffba_owner_table.sv
// Owner table: held flag per owner plus recorded block start and length.
`default_nettype none

module ffba_owner_table #(
  parameter int DEPTH   = 256,
  parameter int AW      = 8,
  parameter int START_W = 10,
  parameter int LEN_W   = 11
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [AW-1:0]          rd_addr_i,
  output logic                   rd_valid_o,
  output logic [START_W-1:0]     rd_start_o,
  output logic [LEN_W-1:0]       rd_len_o,
  input  ffba_pkg::ffba_own_wr_t wr_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [START_W-1:0]     wr_start_i,
  input  logic [LEN_W-1:0]       wr_len_i
);

  logic [DEPTH-1:0]   valid_q;
  logic [START_W-1:0] start_mem_q [DEPTH];
  logic [LEN_W-1:0]   len_mem_q   [DEPTH];
  logic               rd_valid_q;
  logic [START_W-1:0] rd_start_q;
  logic [LEN_W-1:0]   rd_len_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.set) begin
      start_mem_q[wr_addr_i] <= wr_start_i;
      len_mem_q[wr_addr_i]   <= wr_len_i;
    end
    if (rd_en_i) begin
      rd_start_q <= start_mem_q[rd_addr_i];
      rd_len_q   <= len_mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.set) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (wr_i.clr) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_start_o = rd_start_q;
  assign rd_len_o   = rd_len_q;

endmodule

`default_nettype wire

### hw/rtl/ffba_run_unit.sv
// Row scan unit: extends the free run over one row and finds the first fit.
`default_nettype none

module ffba_run_unit #(
  parameter int POS_W = 11
) (
  input  logic [ffba_pkg::ROW_W-1:0] row_i,
  input  logic [POS_W-1:0]           base_i,
  input  logic [POS_W-1:0]           limit_i,
  input  logic [POS_W-1:0]           carry_i,
  input  logic [POS_W-1:0]           len_i,
  output logic                       hit_o,
  output logic [POS_W-2:0]           start_o,
  output logic [POS_W-1:0]           carry_o,
  output logic                       last_o
);

  logic [POS_W-1:0]              rem_slots;
  logic [ffba_pkg::ROW_W-1:0]    free;
  logic [POS_W-1:0]              run [ffba_pkg::ROW_W];
  logic [ffba_pkg::ROW_BITS-1:0] hit_k;

  always_comb begin : run_calc
    logic                          seen;
    logic [ffba_pkg::ROW_BITS-1:0] last_taken;
    rem_slots = limit_i - base_i;
    // Slots past the usable count count as taken.
    for (int k = 0; k < ffba_pkg::ROW_W; k++) begin
      free[k] = !row_i[k] && (rem_slots > POS_W'(k));
    end
    // Run length ending at each slot: from the nearest taken slot, or the carry.
    for (int k = 0; k < ffba_pkg::ROW_W; k++) begin
      seen       = 1'b0;
      last_taken = '0;
      for (int j = 0; j <= k; j++) begin
        if (!free[j]) begin
          seen       = 1'b1;
          last_taken = ffba_pkg::ROW_BITS'(j);
        end
      end
      run[k] = seen ? POS_W'(ffba_pkg::ROW_BITS'(k) - last_taken)
                    : carry_i + POS_W'(k + 1);
    end
    // Lowest slot whose run reaches the length closes the first fit.
    hit_o = 1'b0;
    hit_k = '0;
    for (int k = ffba_pkg::ROW_W - 1; k >= 0; k--) begin
      if (run[k] >= len_i) begin
        hit_o = 1'b1;
        hit_k = ffba_pkg::ROW_BITS'(k);
      end
    end
  end

  assign start_o = (POS_W-1)'(base_i + POS_W'(hit_k) + POS_W'(1) - len_i);
  assign carry_o = run[ffba_pkg::ROW_W-1];
  assign last_o  = rem_slots <= POS_W'(ffba_pkg::ROW_W);

endmodule

`default_nettype wire

### dv/tb.sv
// Testbench of the first-fit block allocator: table-driven and random requests, checked per word.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_SLOTS   = 1024;
  localparam int NUM_OWNERS  = 256;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE      = 100;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 98;

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          cfg_valid_i      = 1'b0;
  logic                          cfg_ready_o;
  logic [ffba_pkg::SEAT_W-1:0]   cfg_seat_count_i = '0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_stall_o;
  logic                          cmd_i            = ffba_pkg::CMD_ALLOC;
  logic [ffba_pkg::ID_W-1:0]     owner_id_i       = '0;
  logic [ffba_pkg::LEN_IN_W-1:0] block_length_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i      = 1'b0;
  logic                          accepted_o;

  first_fit_block_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_seat_count_i (cfg_seat_count_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .owner_id_i       (owner_id_i),
    .block_length_i   (block_length_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the allocator: slot map, owner table and seat count.
  bit                          slot_busy    [NUM_SLOTS];
  bit                          holder_valid [NUM_OWNERS];
  int unsigned                 holder_base  [NUM_OWNERS];
  int unsigned                 holder_len   [NUM_OWNERS];
  logic [ffba_pkg::SEAT_W-1:0] seat_shadow  = ffba_pkg::SEAT_RESET;

  bit grant_queue [$];
  int mismatch_count = 0;
  int idle_cycles    = 0;
  int gap_pct        = 0;
  int stall_pct      = 0;
  bit calm           = 1'b0;

  // Apply one request to the shadow and return whether it is granted.
  function automatic bit allocator_grant(input logic c, input logic [ffba_pkg::ID_W-1:0] id,
                                         input logic [ffba_pkg::LEN_IN_W-1:0] len);
    int unsigned usable;
    int unsigned run_base;
    int unsigned run_len;
    int unsigned j;
    int unsigned z;
    int unsigned last;
    bit          ok;
    usable   = (seat_shadow > NUM_SLOTS) ? NUM_SLOTS : seat_shadow;
    ok       = 1'b0;
    run_base = 0;
    run_len  = 0;
    if (c == ffba_pkg::CMD_ALLOC) begin
      if (!holder_valid[id] && len != 0 && len <= usable) begin
        for (j = 0; j < usable && !ok; j++) begin
          if (slot_busy[j]) begin
            run_len = 0;
          end else begin
            if (run_len == 0) run_base = j;
            run_len++;
            if (run_len >= len) begin
              for (z = run_base; z < run_base + len; z++) slot_busy[z] = 1'b1;
              holder_valid[id] = 1'b1;
              holder_base[id]  = run_base;
              holder_len[id]   = len;
              ok = 1'b1;
            end
          end
        end
      end
    end else if (holder_valid[id]) begin
      last = holder_base[id] + holder_len[id];
      if (last > NUM_SLOTS) last = NUM_SLOTS;
      for (z = holder_base[id]; z < last; z++) slot_busy[z] = 1'b0;
      holder_valid[id] = 1'b0;
      ok = 1'b1;
    end
    return ok;
  endfunction

  // Directed requests; fixed rows carry a grant that is plain from the spec.
  typedef struct packed {
    logic                          cmd;
    logic [ffba_pkg::ID_W-1:0]     id;
    logic [ffba_pkg::LEN_IN_W-1:0] len;
    logic                          fixed;
    logic                          fixed_ok;
  } probe_t;

  localparam int PROBES = 20;
  probe_t probe_tab [PROBES] = '{
    '{ffba_pkg::CMD_ALLOC,   8'd0,   11'd0,    1'b1, 1'b0}, // zero length
    '{ffba_pkg::CMD_ALLOC,   8'd0,   11'd1025, 1'b1, 1'b0}, // longer than the seat count
    '{ffba_pkg::CMD_ALLOC,   8'd0,   11'd2047, 1'b1, 1'b0},
    '{ffba_pkg::CMD_RELEASE, 8'd7,   11'd0,    1'b1, 1'b0}, // owner holds nothing
    '{ffba_pkg::CMD_ALLOC,   8'd0,   11'd1024, 1'b1, 1'b1}, // take the whole map
    '{ffba_pkg::CMD_ALLOC,   8'd1,   11'd1,    1'b1, 1'b0}, // no free run left
    '{ffba_pkg::CMD_ALLOC,   8'd0,   11'd1,    1'b1, 1'b0}, // owner already holds
    '{ffba_pkg::CMD_RELEASE, 8'd0,   11'd2047, 1'b1, 1'b1}, // length ignored on release
    '{ffba_pkg::CMD_ALLOC,   8'd255, 11'd1,    1'b1, 1'b1},
    '{ffba_pkg::CMD_ALLOC,   8'd1,   11'd16,   1'b0, 1'b0},
    '{ffba_pkg::CMD_ALLOC,   8'd2,   11'd17,   1'b0, 1'b0},
    '{ffba_pkg::CMD_ALLOC,   8'd3,   11'd3,    1'b0, 1'b0},
    '{ffba_pkg::CMD_RELEASE, 8'd1,   11'd0,    1'b0, 1'b0},
    '{ffba_pkg::CMD_ALLOC,   8'd4,   11'd15,   1'b0, 1'b0}, // refill part of the hole
    '{ffba_pkg::CMD_ALLOC,   8'd5,   11'd2,    1'b0, 1'b0}, // skip the one-slot gap
    '{ffba_pkg::CMD_RELEASE, 8'd255, 11'd0,    1'b1, 1'b1},
    '{ffba_pkg::CMD_RELEASE, 8'd255, 11'd0,    1'b1, 1'b0}, // second release, same owner
    '{ffba_pkg::CMD_ALLOC,   8'd6,   11'd1,    1'b0, 1'b0},
    '{ffba_pkg::CMD_ALLOC,   8'd128, 11'd1000, 1'b0, 1'b0},
    '{ffba_pkg::CMD_ALLOC,   8'd170, 11'd85,   1'b0, 1'b0}
  };

  // Offer one word, hold it until taken, then log the expected grant.
  task automatic offer_request(input logic c, input logic [ffba_pkg::ID_W-1:0] id,
                               input logic [ffba_pkg::LEN_IN_W-1:0] len,
                               input bit fixed, input bit fixed_ok);
    bit grant;
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    owner_id_i     <= id;
    block_length_i <= len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    grant = allocator_grant(c, id, len);
    grant_queue.push_back(fixed ? fixed_ok : grant);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every grant is back and the block has settled.
  task automatic drain_grants();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (grant_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_seats(input logic [ffba_pkg::SEAT_W-1:0] value);
    cfg_valid_i      <= 1'b1;
    cfg_seat_count_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    seat_shadow = value;
  endtask

  // Random request: mostly a small pool of owners and short blocks.
  task automatic random_request();
    int unsigned                   usable;
    int unsigned                   r;
    logic                          c;
    logic [ffba_pkg::ID_W-1:0]     id;
    logic [ffba_pkg::LEN_IN_W-1:0] len;
    usable = (seat_shadow > NUM_SLOTS) ? NUM_SLOTS : seat_shadow;
    c  = ($urandom_range(0, 99) < 55) ? ffba_pkg::CMD_ALLOC : ffba_pkg::CMD_RELEASE;
    id = ($urandom_range(0, 99) < 80) ? ffba_pkg::ID_W'($urandom_range(0, 23))
                                      : ffba_pkg::ID_W'($urandom_range(0, NUM_OWNERS - 1));
    r  = $urandom_range(0, 99);
    if (r < 70) begin
      len = ffba_pkg::LEN_IN_W'($urandom_range(1, (usable < 6) ? 1 : usable / 6));
    end else if (r < 85) begin
      len = ffba_pkg::LEN_IN_W'($urandom_range(1, (usable < 1) ? 1 : usable));
    end else if (r < 93) begin
      len = $urandom_range(0, 1) ? '0 : ffba_pkg::LEN_IN_W'(usable + 1);
    end else begin
      len = ffba_pkg::LEN_IN_W'($urandom_range(0, 2047));
    end
    offer_request(c, id, len, 1'b0, 1'b0);
  endtask

  // Receiver stall bursts.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (calm || $urandom_range(0, 99) >= stall_pct) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  // Compare each returned word with the oldest expected grant.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grant_queue.size() == 0) begin
        $error("accepted: no result expected, got %0d", accepted_o);
        mismatch_count++;
      end else if (accepted_o !== grant_queue[0]) begin
        $error("accepted: expected %0d, got %0d", grant_queue[0], accepted_o);
        mismatch_count++;
        void'(grant_queue.pop_front());
      end else begin
        void'(grant_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  logic [ffba_pkg::SEAT_W-1:0] phase_seats [PHASES] = '{
    11'd16, 11'd1, 11'd0, 11'd2047, 11'd100, 11'd1000, 11'd600, 11'd1024
  };

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 15;
    stall_pct = 8;
    for (int p = 0; p < PROBES; p++) begin
      maybe_pause();
      offer_request(probe_tab[p].cmd, probe_tab[p].id, probe_tab[p].len,
                    probe_tab[p].fixed, probe_tab[p].fixed_ok);
    end
    drain_grants();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_seats(phase_seats[ph]);
      calm      = (ph == PHASES - 1);
      gap_pct   = (ph % 3 == 0) ? 0 : $urandom_range(5, 30);
      stall_pct = (ph % 3 == 1) ? 0 : $urandom_range(3, 20);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        maybe_pause();
        random_request();
      end
      drain_grants();
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ffba_pkg.sv
hw/rtl/ffba_slot_map.sv
hw/rtl/ffba_owner_table.sv
hw/rtl/ffba_run_unit.sv
hw/rtl/first_fit_block_allocator.sv
dv/tb.sv
